// File: src/gfalu_pkg.sv
`timescale 1ns / 1ps

package gfalu_pkg;

  // Field element width, fixed by the modulus x^64 + x^4 + x^3 + x + 1
  localparam int unsigned FIELD_W = 64;

  // Multiplier digit width: multiplier bits consumed per cycle (divides FIELD_W)
  localparam int unsigned DIGIT_W = 8;

  // Exponent-bit steps of one power or inverse
  localparam int unsigned POW_STEPS = 64;

  // Opcode width and codes
  localparam int unsigned OPCODE_W = 3;
  localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_MUL  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SQR  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_BFLY = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_POW  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_INV  = 3'd5;

  // Inverse is a^(2^64 - 2)
  localparam logic [FIELD_W-1:0] INV_EXP = 64'hFFFF_FFFF_FFFF_FFFE;
  localparam logic [FIELD_W-1:0] FIELD_ONE = 64'd1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_POW,
    ST_FINISH
  } gfalu_state_e;

  // Start request to one serial multiplier
  typedef struct packed {
    logic               start;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
  } mul_req_t;

endpackage

// File: src/gfalu_if.sv
`timescale 1ns / 1ps

// Request channel: one operation per transfer
interface gfalu_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [gfalu_pkg::OPCODE_W-1:0]        opcode;
  logic [gfalu_pkg::FIELD_W-1:0]         operand_a;
  logic [gfalu_pkg::FIELD_W-1:0]         operand_b;
  logic [gfalu_pkg::FIELD_W-1:0]         operand_c;

  modport source (output valid, opcode, operand_a, operand_b, operand_c, input ready);
  modport sink   (input valid, opcode, operand_a, operand_b, operand_c, output ready);
endinterface

// Response channel: one result per transfer
interface gfalu_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [gfalu_pkg::FIELD_W-1:0]         first_value;
  logic [gfalu_pkg::FIELD_W-1:0]         second_value;
  logic                                  zero_inverse;

  modport source (output valid, first_value, second_value, zero_inverse, input ready);
  modport sink   (input valid, first_value, second_value, zero_inverse, output ready);
endinterface

// File: src/gfalu_mul_serial.sv
`timescale 1ns / 1ps

// Digit-serial GF(2^64) multiplier, multiplier operand MSB digit first.
// Each cycle: acc = acc * x^D + x * digit, reduced mod x^64 + x^4 + x^3 + x + 1.
module gfalu_mul_serial #(
  parameter int unsigned DigitW = gfalu_pkg::DIGIT_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gfalu_pkg::mul_req_t           req_i,
  output logic                          done_o,
  output logic [gfalu_pkg::FIELD_W-1:0] product_o
);

  localparam int unsigned FW      = gfalu_pkg::FIELD_W;
  localparam int unsigned NDigits = FW / DigitW;
  localparam int unsigned CntW    = (NDigits > 1) ? $clog2(NDigits) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(NDigits - 1);

  logic [FW-1:0]        x_q;
  logic [FW-1:0]        y_q;
  logic [FW-1:0]        acc_q, acc_d;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DigitW-1:0]    digit;
  logic [FW+DigitW-1:0] wide;
  logic [FW-1:0]        spill;

  // Shift accumulator by one digit, add digit partial products, fold overflow
  always_comb begin
    digit = y_q[FW-1 -: DigitW];
    wide  = {acc_q, {DigitW{1'b0}}};
    for (int i = 0; i < int'(DigitW); i++) begin
      if (digit[i]) begin
        wide = wide ^ ({{DigitW{1'b0}}, x_q} << i);
      end
    end
    spill = {{(FW-DigitW){1'b0}}, wide[FW+DigitW-1:FW]};
    // x^64 = x^4 + x^3 + x + 1; spill degree stays below 60, one fold suffices
    acc_d = wide[FW-1:0] ^ spill ^ (spill << 1) ^ (spill << 3) ^ (spill << 4);
  end

  // Sequence the digit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Load operands and advance the datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= req_i.x;
      y_q   <= req_i.y;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      y_q   <= y_q << DigitW;
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

// File: src/gf64_field_alu_unit.sv
`timescale 1ns / 1ps

// GF(2^64) arithmetic unit, modulus x^64 + x^4 + x^3 + x + 1.
// req_i carries opcode and operands a, b, c; rsp_o returns first_value,
// second_value and zero_inverse, one response per request, in order.
// Both channels transfer when valid and ready are high at a clock edge.
// One operation is in flight at a time; req_i.ready is high while idle.
// Products come from two digit-serial multipliers taking DigitW multiplier
// bits per cycle.
// Add, inverse of zero and unused opcodes finish without a product;
// multiply, square and butterfly take one product; power and inverse
// take one step per exponent bit, 64 steps, each squaring and
// multiplying on both multipliers at once.
// The response sits in an output register; a new request is taken while it
// waits, and a finished result waits in the sequencer until rsp_o drains.
// Reset (rst_ni low, asynchronous) empties the unit and drops any result.
module gf64_field_alu_unit #(
  parameter int unsigned DigitW = gfalu_pkg::DIGIT_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gfalu_in_if.sink          req_i,
  gfalu_out_if.source       rsp_o
);

  localparam int unsigned FW   = gfalu_pkg::FIELD_W;
  localparam int unsigned StpW = $clog2(gfalu_pkg::POW_STEPS);
  localparam logic [StpW-1:0] StepLast = StpW'(gfalu_pkg::POW_STEPS - 1);

  gfalu_pkg::gfalu_state_e state_q, state_d;

  logic [gfalu_pkg::OPCODE_W-1:0] op_q;
  logic [FW-1:0] a_q, b_q, acc_q;
  logic [StpW-1:0] step_q;
  logic [FW-1:0] res_first_q, res_second_q;
  logic          res_zinv_q;
  logic [FW-1:0] out_first_q, out_second_q;
  logic          out_zinv_q;
  logic          out_valid_q;

  gfalu_pkg::mul_req_t mreq0, mreq1;
  logic          done0, done1;
  logic [FW-1:0] prod0, prod1;

  logic          accept;
  logic          a_zero;
  logic          pow_done;
  logic          pow_last;
  logic          out_load;
  logic [FW-1:0] acc_nxt, base_nxt;

  gfalu_mul_serial #(.DigitW(DigitW)) u_mul0 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mreq0),
    .done_o    (done0),
    .product_o (prod0)
  );

  gfalu_mul_serial #(.DigitW(DigitW)) u_mul1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mreq1),
    .done_o    (done1),
    .product_o (prod1)
  );

  assign accept   = req_i.valid && req_i.ready;
  assign a_zero   = (req_i.operand_a == '0);
  assign pow_done = (state_q == gfalu_pkg::ST_POW) && done0 && done1;
  assign pow_last = (step_q == StepLast);
  assign acc_nxt  = b_q[0] ? prod0 : acc_q;
  assign base_nxt = prod1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gfalu_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.opcode)
            gfalu_pkg::OP_MUL, gfalu_pkg::OP_SQR, gfalu_pkg::OP_BFLY:
              state_d = gfalu_pkg::ST_MUL;
            gfalu_pkg::OP_POW: state_d = gfalu_pkg::ST_POW;
            gfalu_pkg::OP_INV:
              state_d = a_zero ? gfalu_pkg::ST_FINISH : gfalu_pkg::ST_POW;
            default: state_d = gfalu_pkg::ST_FINISH;
          endcase
        end
      end
      gfalu_pkg::ST_MUL: begin
        if (done0) state_d = gfalu_pkg::ST_FINISH;
      end
      gfalu_pkg::ST_POW: begin
        if (pow_done && pow_last) state_d = gfalu_pkg::ST_FINISH;
      end
      gfalu_pkg::ST_FINISH: begin
        if (out_load) state_d = gfalu_pkg::ST_IDLE;
      end
      default: state_d = gfalu_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and multiplier requests
  always_comb begin
    req_i.ready = (state_q == gfalu_pkg::ST_IDLE);
    out_load    = (state_q == gfalu_pkg::ST_FINISH) && (!out_valid_q || rsp_o.ready);
    mreq0       = '0;
    mreq1       = '0;
    case (state_q)
      gfalu_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.opcode)
            gfalu_pkg::OP_MUL: begin
              mreq0 = '{start: 1'b1, x: req_i.operand_a, y: req_i.operand_b};
            end
            gfalu_pkg::OP_SQR: begin
              mreq0 = '{start: 1'b1, x: req_i.operand_a, y: req_i.operand_a};
            end
            gfalu_pkg::OP_BFLY: begin
              mreq0 = '{start: 1'b1, x: req_i.operand_c, y: req_i.operand_a};
            end
            gfalu_pkg::OP_POW, gfalu_pkg::OP_INV: begin
              if (req_i.opcode == gfalu_pkg::OP_POW || !a_zero) begin
                mreq0 = '{start: 1'b1, x: gfalu_pkg::FIELD_ONE, y: req_i.operand_a};
                mreq1 = '{start: 1'b1, x: req_i.operand_a, y: req_i.operand_a};
              end
            end
            default: begin
              mreq0 = '0;
            end
          endcase
        end
      end
      gfalu_pkg::ST_POW: begin
        // Restart both products for the next exponent bit
        if (pow_done && !pow_last) begin
          mreq0 = '{start: 1'b1, x: acc_nxt, y: base_nxt};
          mreq1 = '{start: 1'b1, x: base_nxt, y: base_nxt};
        end
      end
      default: begin
        mreq0 = '0;
      end
    endcase
  end

  // Hold state, step count and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gfalu_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
      end else if (pow_done) begin
        step_q <= step_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operand, accumulator and result datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.opcode;
      a_q   <= req_i.operand_a;
      b_q   <= (req_i.opcode == gfalu_pkg::OP_INV) ? gfalu_pkg::INV_EXP : req_i.operand_b;
      acc_q <= gfalu_pkg::FIELD_ONE;
      res_first_q  <= (req_i.opcode == gfalu_pkg::OP_ADD) ?
                      (req_i.operand_a ^ req_i.operand_b) : '0;
      res_second_q <= '0;
      res_zinv_q   <= (req_i.opcode == gfalu_pkg::OP_INV) && a_zero;
    end else if (state_q == gfalu_pkg::ST_MUL && done0) begin
      // Butterfly: b' = b + c*a, a' = a + b'
      if (op_q == gfalu_pkg::OP_BFLY) begin
        res_second_q <= b_q ^ prod0;
        res_first_q  <= a_q ^ b_q ^ prod0;
      end else begin
        res_first_q  <= prod0;
      end
    end else if (pow_done) begin
      acc_q <= acc_nxt;
      a_q   <= base_nxt;
      b_q   <= b_q >> 1;
      if (pow_last) begin
        res_first_q <= acc_nxt;
      end
    end
    if (out_load) begin
      out_first_q  <= res_first_q;
      out_second_q <= res_second_q;
      out_zinv_q   <= res_zinv_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.first_value  = out_first_q;
  assign rsp_o.second_value = out_second_q;
  assign rsp_o.zero_inverse = out_zinv_q;

endmodule

// File: verif/gfalu_result_checker.sv
`timescale 1ns / 1ps

// Watch both channels of the GF(2^64) unit, predict every response from the
// request that caused it, and compare in order.
module gfalu_result_checker
  import gfalu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  gfalu_in_if   req_i,
  gfalu_out_if  rsp_i,
  output int    fail_count_o,
  output int    pending_o
);

  typedef struct packed {
    logic [FIELD_W-1:0] first_value;
    logic [FIELD_W-1:0] second_value;
    logic               zero_inverse;
  } gf_result_t;

  // x^64 + x^4 + x^3 + x + 1 as a 128-bit vector
  localparam logic [2*FIELD_W-1:0] FIELD_POLY = {63'd0, 1'b1, 64'h1B};

  gf_result_t pending_results[$];

  // Carry-less product, then clear the upper bits one at a time from the top
  function automatic logic [FIELD_W-1:0] gf_mul(input logic [FIELD_W-1:0] x,
                                                input logic [FIELD_W-1:0] y);
    logic [2*FIELD_W-1:0] prod;
    prod = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (y[i]) prod ^= {{FIELD_W{1'b0}}, x} << i;
    end
    for (int i = 2 * FIELD_W - 2; i >= FIELD_W; i--) begin
      if (prod[i]) prod ^= FIELD_POLY << (i - FIELD_W);
    end
    return prod[FIELD_W-1:0];
  endfunction

  // Square-and-multiply, least significant exponent bit first
  function automatic logic [FIELD_W-1:0] gf_pow(input logic [FIELD_W-1:0] base,
                                                input logic [FIELD_W-1:0] exponent);
    logic [FIELD_W-1:0] acc;
    logic [FIELD_W-1:0] sq;
    acc = FIELD_ONE;
    sq  = base;
    for (int i = 0; i < FIELD_W; i++) begin
      if (exponent[i]) acc = gf_mul(acc, sq);
      sq = gf_mul(sq, sq);
    end
    return acc;
  endfunction

  function automatic gf_result_t field_result(input logic [OPCODE_W-1:0] op,
                                              input logic [FIELD_W-1:0]  a,
                                              input logic [FIELD_W-1:0]  b,
                                              input logic [FIELD_W-1:0]  c);
    gf_result_t res;
    res = '0;
    case (op)
      OP_ADD: res.first_value = a ^ b;
      OP_MUL: res.first_value = gf_mul(a, b);
      OP_SQR: res.first_value = gf_mul(a, a);
      OP_BFLY: begin
        res.second_value = b ^ gf_mul(c, a);
        res.first_value  = a ^ res.second_value;
      end
      OP_POW: res.first_value = gf_pow(a, b);
      OP_INV: begin
        // zero has no inverse: flag it and return zero
        if (a == '0) res.zero_inverse = 1'b1;
        else res.first_value = gf_pow(a, INV_EXP);
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_field(input string name, input logic [FIELD_W-1:0] want,
                              input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  // Retire the response transfer first, then queue the request transfer
  always @(posedge clk_i) begin : watch
    gf_result_t want;
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: response with none outstanding: expected nothing, actual %h %h %b",
                   $time, rsp_i.first_value, rsp_i.second_value, rsp_i.zero_inverse);
          fail_count_o++;
        end else begin
          want = pending_results.pop_front();
          report_field("first_value", want.first_value, rsp_i.first_value);
          report_field("second_value", want.second_value, rsp_i.second_value);
          report_field("zero_inverse", {{(FIELD_W-1){1'b0}}, want.zero_inverse},
                       {{(FIELD_W-1){1'b0}}, rsp_i.zero_inverse});
        end
      end
      if (req_i.valid && req_i.ready) begin
        pending_results.push_back(field_result(req_i.opcode, req_i.operand_a,
                                               req_i.operand_b, req_i.operand_c));
      end
      pending_o = pending_results.size();
    end
  end

endmodule

// File: verif/tb_gf64_field_alu_unit.sv
`timescale 1ns / 1ps

module tb_gf64_field_alu_unit;
  import gfalu_pkg::*;

  // Opcodes the unit leaves unused
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic [FIELD_W-1:0] ALL_ONES = '1;
  localparam logic [FIELD_W-1:0] TOP_BIT  = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned MAX_WAIT     = 17;
  localparam int unsigned DRAIN_CYCLES = 600;

  logic clk = 1'b0;
  logic rst_n;
  logic no_idle;
  int   fail_count;
  int   outstanding;

  gfalu_in_if  req_if ();
  gfalu_out_if rsp_if ();

  gf64_field_alu_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  gfalu_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (outstanding)
  );

  always #5 clk = ~clk;

  // Hang guard, several times the slowest legal run
  initial begin
    #(64'd50_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // Idle a random count, present one request at the falling edge, hold until transfer
  task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [FIELD_W-1:0] a,
                         input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] c);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.opcode    <= op;
    req_if.operand_a <= a;
    req_if.operand_b <= b;
    req_if.operand_c <= c;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Drop valid and hold off until every response is back
  task automatic drain_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    wait (outstanding == 0);
  endtask

  // Field element biased toward edge patterns
  function automatic logic [FIELD_W-1:0] pick_element();
    logic [FIELD_W-1:0] one_hot;
    one_hot = {{(FIELD_W-1){1'b0}}, 1'b1} << $urandom_range(0, FIELD_W - 1);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return one_hot;
      3:       return ~one_hot;
      4:       return FIELD_W'($urandom_range(0, 255));
      5:       return {8'($urandom_range(0, 255)), 24'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Response side: stall a random count per transfer, with stall-free stretches
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clk);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  // Request side and verdict
  initial begin
    int unsigned        pick;
    logic [OPCODE_W-1:0] op;
    logic [FIELD_W-1:0]  a;
    logic [FIELD_W-1:0]  b;
    logic [FIELD_W-1:0]  c;

    no_idle          = 1'b0;
    req_if.valid     = 1'b0;
    req_if.opcode    = OP_ADD;
    req_if.operand_a = '0;
    req_if.operand_b = '0;
    req_if.operand_c = '0;
    rst_n            = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, each opcode, the special cases
    send_op(OP_ADD,  '0, '0, ALL_ONES);
    send_op(OP_ADD,  ALL_ONES, 64'h5555_AAAA_0F0F_F0F0, '0);
    send_op(OP_MUL,  ALL_ONES, ALL_ONES, ALL_ONES);
    send_op(OP_MUL,  TOP_BIT, TOP_BIT, '0);
    send_op(OP_MUL,  FIELD_ONE, 64'h0123_4567_89AB_CDEF, '0);
    send_op(OP_MUL,  '0, ALL_ONES, '0);
    send_op(OP_SQR,  ALL_ONES, '0, ALL_ONES);
    send_op(OP_SQR,  TOP_BIT, ALL_ONES, '0);
    send_op(OP_BFLY, ALL_ONES, ALL_ONES, ALL_ONES);
    send_op(OP_BFLY, 64'hDEAD_BEEF_0000_0001, 64'h1234, '0);
    send_op(OP_BFLY, TOP_BIT, '0, FIELD_ONE);
    // exponent zero gives one, also for a zero base
    send_op(OP_POW,  '0, '0, '0);
    send_op(OP_POW,  64'hCAFE_F00D_1234_5678, '0, ALL_ONES);
    send_op(OP_POW,  64'hCAFE_F00D_1234_5678, FIELD_ONE, '0);
    send_op(OP_POW,  TOP_BIT, ALL_ONES, '0);
    send_op(OP_POW,  '0, 64'd5, '0);
    // inverse of zero raises the flag
    send_op(OP_INV,  '0, ALL_ONES, ALL_ONES);
    send_op(OP_INV,  FIELD_ONE, '0, '0);
    send_op(OP_INV,  ALL_ONES, '0, '0);
    send_op(OP_INV,  TOP_BIT, '0, '0);
    send_op(OP_SPARE_LO, ALL_ONES, ALL_ONES, ALL_ONES);
    send_op(OP_SPARE_HI, ALL_ONES, ALL_ONES, ALL_ONES);
    drain_results();

    // Random: mixed opcodes, stall-free stretches, one mid-run drain
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = ((n / 200) % 4 == 3);
      if (n == RANDOM_ITEMS / 2) drain_results();
      a    = pick_element();
      b    = pick_element();
      c    = pick_element();
      pick = $urandom_range(0, 99);
      if (pick < 16) op = OP_ADD;
      else if (pick < 32) op = OP_MUL;
      else if (pick < 44) op = OP_SQR;
      else if (pick < 64) op = OP_BFLY;
      else if (pick < 77) op = OP_POW;
      else if (pick < 90) op = OP_INV;
      else if (pick < 95) op = OP_SPARE_LO;
      else op = OP_SPARE_HI;
      // keep zero inputs to inversion occasional
      if (op == OP_INV && a == '0 && $urandom_range(0, 3) != 0) begin
        a = {$urandom, $urandom} | FIELD_ONE;
      end
      send_op(op, a, b, c);
    end
    drain_results();
    no_idle = 1'b0;

    // Catch any stray response
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
